@@ hw/rtl/lqle_pkg.sv @@
// Shared types, constants and preset weights for the linear Q-learning engine.
`default_nettype none
package lqle_pkg;

    localparam int DEF_BEHAVIORS = 5;
    localparam int NFEAT         = 6;
    localparam int FW            = 17;
    localparam int WW            = 32;
    localparam int QW            = 48;
    localparam int CBW           = 3;
    localparam int PRESET_ROWS   = 5;

    localparam logic [15:0] LR_RESET   = 16'd66;
    localparam logic [15:0] DISC_RESET = 16'd64881;

    typedef enum logic [1:0] {
        OP_GREEDY = 2'd0,
        OP_FORCED = 2'd1,
        OP_UPDATE = 2'd2,
        OP_HOLD   = 2'd3
    } op_t;

    typedef enum logic {
        REG_LEARNING_RATE = 1'b0,
        REG_DISCOUNT      = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [CBW-1:0]       chosen;
        logic signed [QW-1:0] q;
        logic signed [QW-1:0] td;
    } result_t;

    localparam logic signed [WW-1:0] PRESET [PRESET_ROWS][NFEAT] = '{
        '{ 32'sd105588457, 32'sd108435341, 32'sd19814207, 32'sd54562233,
          -32'sd79135297, 32'sd5612115 },
        '{ 32'sd313149882, 32'sd124515254, 32'sd2923409, 32'sd132320854,
          -32'sd191534989, 32'sd50547340 },
        '{ 32'sd211314278, 32'sd131871015, 32'sd114004328, 32'sd46469847,
          -32'sd55352544, 32'sd5665309 },
        '{ 32'sd103033078, 32'sd101020756, 32'sd23925359, 32'sd58852586,
          -32'sd94989556, 32'sd10351395 },
        '{ 32'sd78916459, 32'sd93569889, 32'sd10937067, 32'sd69560225,
          -32'sd193213759, 32'sd19411344 }
    };

    function automatic logic signed [WW-1:0] preset_weight(input int b, input int k);
        logic signed [WW-1:0] w;
        w = '0;
        if (b < PRESET_ROWS && k < NFEAT)
        begin
            w = PRESET[b][k];
        end
        return w;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/lqle_wmem.sv @@
// Weight memory: synchronous read, one write port, valid bits over the preset table.
`default_nettype none
module lqle_wmem
    import lqle_pkg::*;
#(
    parameter int BEHAVIORS = DEF_BEHAVIORS
)(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [$clog2(BEHAVIORS)-1:0]  rd_b,
    input  wire logic [2:0]                    rd_k,
    output logic signed [WW-1:0]               rd_w,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(BEHAVIORS)-1:0]  wr_b,
    input  wire logic [2:0]                    wr_k,
    input  wire logic signed [WW-1:0]          wr_data
);
    localparam int DEPTH = BEHAVIORS * NFEAT;
    localparam int AW    = $clog2(DEPTH);

    logic signed [WW-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     vld_reg;
    logic signed [WW-1:0] rd_data_reg;
    logic signed [WW-1:0] rd_preset_reg;
    logic                 rd_vld_reg;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;

    assign rd_addr = AW'(int'(rd_b) * NFEAT + int'(rd_k));
    assign wr_addr = AW'(int'(wr_b) * NFEAT + int'(wr_k));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg   <= mem[rd_addr];
        rd_preset_reg <= preset_weight(int'(rd_b), int'(rd_k));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_w = rd_vld_reg ? rd_data_reg : rd_preset_reg;

endmodule
`default_nettype wire

@@ hw/rtl/lqle_ctrl.sv @@
// Sequencer and shared MAC datapath: scoring, TD error and weight update.
`default_nettype none
module lqle_ctrl
    import lqle_pkg::*;
#(
    parameter int BEHAVIORS = DEF_BEHAVIORS
)(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [1:0]                    op,
    input  wire logic [CBW-1:0]                forced,
    input  wire logic [NFEAT-2:0][FW-1:0]      feat,
    input  wire logic signed [15:0]            reward,
    input  wire logic                          finished,
    input  wire logic [15:0]                   lr,
    input  wire logic [15:0]                   disc,
    output logic                               busy,
    output logic                               done,
    input  wire logic                          take,
    output result_t                            res,
    output logic [$clog2(BEHAVIORS)-1:0]       rd_b,
    output logic [2:0]                         rd_k,
    input  wire logic signed [WW-1:0]          rd_w,
    output logic                               wr_en,
    output logic [$clog2(BEHAVIORS)-1:0]       wr_b,
    output logic [2:0]                         wr_k,
    output logic signed [WW-1:0]               wr_data
);
    localparam int BW = $clog2(BEHAVIORS);
    localparam logic [2:0] KLAST = 3'(NFEAT - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCORE = 8'b0000_0010,
        S_GQ    = 8'b0000_0100,
        S_ERR   = 8'b0000_1000,
        S_AQ    = 8'b0001_0000,
        S_LE    = 8'b0010_0000,
        S_UPD   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    op_t                  op_reg;
    logic                 fin_reg;
    logic signed [15:0]   reward_reg;
    logic [NFEAT-2:0][FW-1:0] feat_reg;
    logic [NFEAT-2:0][FW-1:0] sfeat_reg;
    logic [BW-1:0]        sbeh_reg;
    logic signed [QW-1:0] sq_reg;

    logic                 issue_reg;
    logic [BW-1:0]        sb_reg, bend_reg, bstart_reg;
    logic [2:0]           sk_reg;
    logic                 p1_v_reg, p2_v_reg;
    logic [BW-1:0]        p1_b_reg, p2_b_reg;
    logic [2:0]           p1_k_reg, p2_k_reg;
    logic signed [49:0]   prod_reg;
    logic signed [52:0]   acc_reg;
    logic signed [QW-1:0] best_reg;
    logic [BW-1:0]        pick_reg;

    logic signed [64:0]   gq_reg;
    logic signed [QW-1:0] err_reg;
    logic signed [64:0]   aq_reg;
    logic signed [46:0]   le_reg;
    logic signed [64:0]   uprod_reg;
    logic [2:0]           uk_reg;
    logic                 uph_reg;

    logic [BW-1:0]        forced_b;
    logic signed [17:0]   fs_score, fs_upd;
    logic signed [52:0]   acc_sum, acc_rnd;
    logic signed [36:0]   q_row;
    logic signed [64:0]   gq_rnd, aq_rnd, up_rnd;
    logic signed [65:0]   e_wide;
    logic signed [QW-1:0] err_sat;
    logic signed [48:0]   le_wide;
    logic signed [46:0]   le_sat;
    logic signed [49:0]   w_wide;
    logic signed [WW-1:0] w_sat;
    logic                 score_last;

    function automatic logic signed [17:0] fsel(input logic [NFEAT-2:0][FW-1:0] f,
                                                input logic [2:0] k);
        logic signed [17:0] v;
        v = 18'sd65536;
        if (k != 3'd0)
        begin
            v = $signed({1'b0, f[k - 3'd1]});
        end
        return v;
    endfunction

    always_comb
    begin
        if (int'(forced) > BEHAVIORS - 1)
        begin
            forced_b = BW'(BEHAVIORS - 1);
        end
        else
        begin
            forced_b = BW'(forced);
        end
    end

    assign fs_score = fsel(feat_reg, p1_k_reg);
    assign fs_upd   = fsel(sfeat_reg, uk_reg);
    assign acc_sum  = ((p2_k_reg == 3'd0) ? 53'sd0 : acc_reg) + 53'(prod_reg);
    assign acc_rnd  = acc_sum + 53'sd32768;
    assign q_row    = acc_rnd[52:16];
    assign score_last = p2_v_reg && (p2_k_reg == KLAST) && (p2_b_reg == bend_reg);

    assign gq_rnd = gq_reg + 65'sd32768;
    assign e_wide = (66'(reward_reg) <<< 20) + 66'($signed(gq_rnd[64:16])) - 66'(sq_reg);
    always_comb
    begin
        err_sat = e_wide[QW-1:0];
        if (e_wide[65:47] != {19{e_wide[47]}})
        begin
            err_sat = e_wide[65] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end
    end

    assign aq_rnd  = aq_reg + 65'sd32768;
    assign le_wide = aq_rnd[64:16];
    always_comb
    begin
        le_sat = le_wide[46:0];
        if (le_wide[48:46] != {3{le_wide[46]}})
        begin
            le_sat = le_wide[48] ? {1'b1, 46'd0} : {1'b0, {46{1'b1}}};
        end
    end

    assign up_rnd = uprod_reg + 65'sd32768;
    assign w_wide = 50'(rd_w) + 50'($signed(up_rnd[64:16]));
    always_comb
    begin
        w_sat = w_wide[WW-1:0];
        if (w_wide[49:31] != {19{w_wide[31]}})
        begin
            w_sat = w_wide[49] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
    end

    always_comb
    begin
        rd_b = sb_reg;
        rd_k = sk_reg;
        if (state_reg == S_UPD)
        begin
            rd_b = sbeh_reg;
            rd_k = uk_reg;
        end
    end

    assign wr_en   = (state_reg == S_UPD) && uph_reg;
    assign wr_b    = sbeh_reg;
    assign wr_k    = uk_reg;
    assign wr_data = w_sat;

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        res.chosen = CBW'(pick_reg);
        res.q      = best_reg;
        res.td     = '0;
        if (op_reg == OP_HOLD)
        begin
            res.chosen = CBW'(sbeh_reg);
            res.q      = sq_reg;
        end
        else if (op_reg == OP_UPDATE)
        begin
            res.td = err_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op_t'(op) == OP_HOLD)
                    begin
                        state_next = S_DONE;
                    end
                    else if (op_t'(op) == OP_UPDATE && finished)
                    begin
                        state_next = S_GQ;
                    end
                    else
                    begin
                        state_next = S_SCORE;
                    end
                end
            end
            S_SCORE:
            begin
                if (score_last)
                begin
                    state_next = (op_reg == OP_UPDATE) ? S_GQ : S_DONE;
                end
            end
            S_GQ:  state_next = S_ERR;
            S_ERR: state_next = S_AQ;
            S_AQ:  state_next = S_LE;
            S_LE:  state_next = S_UPD;
            S_UPD:
            begin
                if (uph_reg && uk_reg == KLAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_GREEDY;
            fin_reg   <= 1'b0;
            sfeat_reg <= '0;
            sbeh_reg  <= '0;
            sq_reg    <= '0;
            issue_reg <= 1'b0;
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            sb_reg    <= '0;
            sk_reg    <= '0;
            bend_reg  <= '0;
            bstart_reg <= '0;
            uk_reg    <= '0;
            uph_reg   <= 1'b0;
            pick_reg  <= '0;
            best_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p1_v_reg  <= issue_reg;
            p2_v_reg  <= p1_v_reg;

            if (state_reg == S_IDLE && start)
            begin
                op_reg   <= op_t'(op);
                fin_reg  <= finished;
                pick_reg <= '0;
                best_reg <= '0;
                sk_reg   <= '0;
                uk_reg   <= '0;
                uph_reg  <= 1'b0;
                issue_reg <= (op_t'(op) != OP_HOLD) && !(op_t'(op) == OP_UPDATE && finished);
                if (op_t'(op) == OP_FORCED)
                begin
                    sb_reg     <= forced_b;
                    bstart_reg <= forced_b;
                    bend_reg   <= forced_b;
                end
                else
                begin
                    sb_reg     <= '0;
                    bstart_reg <= '0;
                    bend_reg   <= BW'(BEHAVIORS - 1);
                end
            end

            if (issue_reg)
            begin
                if (sk_reg == KLAST)
                begin
                    sk_reg <= '0;
                    if (sb_reg == bend_reg)
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        sb_reg <= sb_reg + 1'b1;
                    end
                end
                else
                begin
                    sk_reg <= sk_reg + 3'd1;
                end
            end

            if (p2_v_reg && p2_k_reg == KLAST)
            begin
                if (p2_b_reg == bstart_reg || 48'(q_row) > best_reg)
                begin
                    best_reg <= 48'(q_row);
                    pick_reg <= p2_b_reg;
                end
            end

            if (state_reg == S_UPD)
            begin
                uph_reg <= !uph_reg;
                if (uph_reg)
                begin
                    uk_reg <= uk_reg + 3'd1;
                end
            end

            if (state_reg == S_DONE && take)
            begin
                if (op_reg == OP_GREEDY || op_reg == OP_FORCED)
                begin
                    sbeh_reg  <= pick_reg;
                    sfeat_reg <= feat_reg;
                    sq_reg    <= best_reg;
                end
                else if (op_reg == OP_UPDATE && !fin_reg)
                begin
                    sbeh_reg  <= pick_reg;
                    sfeat_reg <= feat_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            feat_reg   <= feat;
            reward_reg <= reward;
        end
        p1_b_reg <= sb_reg;
        p1_k_reg <= sk_reg;
        p2_b_reg <= p1_b_reg;
        p2_k_reg <= p1_k_reg;
        prod_reg <= fs_score * rd_w;
        if (p2_v_reg)
        begin
            acc_reg <= acc_sum;
        end
        gq_reg    <= $signed({1'b0, disc}) * best_reg;
        if (state_reg == S_ERR)
        begin
            err_reg <= err_sat;
        end
        aq_reg    <= $signed({1'b0, lr}) * err_reg;
        if (state_reg == S_LE)
        begin
            le_reg <= le_sat;
        end
        uprod_reg <= le_reg * fs_upd;
    end

endmodule
`default_nettype wire

@@ hw/rtl/linear_q_learning_engine_core.sv @@
// Linear Q-learning engine: top level with register port and output register.
//
// Usage: an item enters on item_valid/item_stall carrying op, forced_behavior,
// five Q1.16 features, reward and finished. One result item leaves on
// result_valid/result_stall with chosen_behavior, q_value and td_error.
// Items are worked one at a time; item_stall is high while one is in flight.
// The shared MAC walks the weight memory port one weight a cycle through a
// three-stage read/multiply/add pipe, over every behavior for select (op 0)
// and an unfinished update (op 2), over the forced one for forced select (op 1).
// The finished result sits in an output register; a stalled receiver holds it
// and the block keeps the next item waiting until the register frees.
// Reset restores the preset weights (valid bits per weight), clears the saved
// behavior, features and Q, and loads the default learning rate and discount.
// Registers: learning_rate at 0x0, discount at 0x4. The user must write them
// only while idle; the block itself does not enforce it.
`default_nettype none
module linear_q_learning_engine_core
    import lqle_pkg::*;
#(
    parameter int BEHAVIORS = DEF_BEHAVIORS
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire logic [1:0]           op,
    input  wire logic [2:0]           forced_behavior,
    input  wire logic [16:0]          feature_one,
    input  wire logic [16:0]          feature_two,
    input  wire logic [16:0]          feature_three,
    input  wire logic [16:0]          feature_four,
    input  wire logic [16:0]          feature_five,
    input  wire logic signed [15:0]   reward,
    input  wire logic                 finished,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [2:0]                chosen_behavior,
    output logic signed [47:0]        q_value,
    output logic signed [47:0]        td_error
);
    localparam int BW = $clog2(BEHAVIORS);

    logic [15:0]              lr_reg, disc_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;
    logic                     busy, done, take, start;
    result_t                  res;
    logic [NFEAT-2:0][FW-1:0] feat;
    logic [BW-1:0]            rd_b, wr_b;
    logic [2:0]               rd_k, wr_k;
    logic signed [WW-1:0]     rd_w, wr_data;
    logic                     wr_en;
    reg_idx_t                 ridx;

    assign pready = 1'b1;
    assign ridx   = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg   <= LR_RESET;
            disc_reg <= DISC_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ridx)
                REG_LEARNING_RATE: lr_reg   <= pwdata[15:0];
                REG_DISCOUNT:      disc_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_LEARNING_RATE: prdata = {16'd0, lr_reg};
            REG_DISCOUNT:      prdata = {16'd0, disc_reg};
            default:           prdata = '0;
        endcase
    end

    assign feat       = {feature_five, feature_four, feature_three, feature_two, feature_one};
    assign item_stall = busy;
    assign start      = item_valid && !busy;
    assign take       = !out_valid_reg || !result_stall;

    lqle_ctrl #(.BEHAVIORS(BEHAVIORS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .op       (op),
        .forced   (forced_behavior),
        .feat     (feat),
        .reward   (reward),
        .finished (finished),
        .lr       (lr_reg),
        .disc     (disc_reg),
        .busy     (busy),
        .done     (done),
        .take     (take),
        .res      (res),
        .rd_b     (rd_b),
        .rd_k     (rd_k),
        .rd_w     (rd_w),
        .wr_en    (wr_en),
        .wr_b     (wr_b),
        .wr_k     (wr_k),
        .wr_data  (wr_data)
    );

    lqle_wmem #(.BEHAVIORS(BEHAVIORS)) u_wmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_b    (rd_b),
        .rd_k    (rd_k),
        .rd_w    (rd_w),
        .wr_en   (wr_en),
        .wr_b    (wr_b),
        .wr_k    (wr_k),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done && take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && take)
        begin
            out_reg <= res;
        end
    end

    assign result_valid    = out_valid_reg;
    assign chosen_behavior = out_reg.chosen;
    assign q_value         = out_reg.q;
    assign td_error        = out_reg.td;

endmodule
`default_nettype wire
